// File: src/assert_macros.svh
// assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock outside reset
`define CHK_IMPL(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("check failed");
// next-cycle implication checked outside reset
`define CHK_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("check failed");
`endif

// File: src/pfpl_pkg.sv
// ----------------------------------------------------------------------------
// pfpl_pkg
// shared types, constants and command codes of the face point locator
// ----------------------------------------------------------------------------
`default_nettype none
package pfpl_pkg;
  localparam int MAX_FACES    = 256;
  localparam int MAX_LOOPS    = 512;
  localparam int MAX_EDGES    = 4096;
  localparam int MAX_VERTICES = 4096;
  localparam int COORD_BITS   = 16;

  localparam logic [2:0] CMD_FACE  = 3'd0;
  localparam logic [2:0] CMD_LOOP  = 3'd1;
  localparam logic [2:0] CMD_EDGE  = 3'd2;
  localparam logic [2:0] CMD_VERT  = 3'd3;
  localparam logic [2:0] CMD_BUILD = 3'd4;
  localparam logic [2:0] CMD_QUERY = 3'd5;

  localparam logic [1:0] REG_FACE_COUNT = 2'd0;
  localparam logic [1:0] REG_LOOP_COUNT = 2'd1;
  localparam logic [1:0] REG_EDGE_COUNT = 2'd2;

  localparam logic signed [15:0] CMAX = 16'sh7fff;
  localparam logic signed [15:0] CMIN = -16'sh8000;

  typedef struct packed {
    logic signed [15:0] lx;
    logic signed [15:0] ly;
    logic signed [15:0] hx;
    logic signed [15:0] hy;
  } box_t;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD,
    OP_RD_FACE, OP_RD_LOOP, OP_RD_EDGE, OP_RD_VERT,
    OP_FBOX_RD, OP_LBOX_RD
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [12:0] addr;
  } pfpl_cmd_t;

  function automatic logic box_has(box_t b, logic signed [15:0] px,
                                   logic signed [15:0] py);
    return b.lx < px && b.hx > px && b.ly < py && b.hy > py;
  endfunction
endpackage
`default_nettype wire

// File: src/pfpl_if.sv
// ----------------------------------------------------------------------------
// pfpl_if
// valid/ready channel interfaces for items, results and configuration
// ----------------------------------------------------------------------------
`default_nettype none
interface pfpl_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         cmd;
  logic [11:0]        index;
  logic [12:0]        start_value;
  logic signed [15:0] point_x;
  logic signed [15:0] point_y;
  modport source (output valid, cmd, index, start_value, point_x, point_y,
                  input ready);
  modport sink   (input valid, cmd, index, start_value, point_x, point_y,
                  output ready);
endinterface

interface pfpl_out_if;
  logic       valid;
  logic       ready;
  logic       found;
  logic [7:0] face_index;
  modport source (output valid, found, face_index, input ready);
  modport sink   (input valid, found, face_index, output ready);
endinterface

interface pfpl_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [12:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: src/pfpl_mem.sv
// ----------------------------------------------------------------------------
// pfpl_mem
// mesh tables and box stores, one registered read port each
// ----------------------------------------------------------------------------
`default_nettype none
module pfpl_mem
  import pfpl_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        fls_we,
  input  wire logic [7:0]  fls_wa,
  input  wire logic [9:0]  fls_wd,
  input  wire logic [7:0]  fls_ra,
  output      logic [9:0]  fls_rd,
  input  wire logic        les_we,
  input  wire logic [8:0]  les_wa,
  input  wire logic [12:0] les_wd,
  input  wire logic [8:0]  les_ra,
  output      logic [12:0] les_rd,
  input  wire logic        ev_we,
  input  wire logic [11:0] ev_wa,
  input  wire logic [11:0] ev_wd,
  input  wire logic [11:0] ev_ra,
  output      logic [11:0] ev_rd,
  input  wire logic        vx_we,
  input  wire logic [11:0] vx_wa,
  input  wire logic [31:0] vx_wd,
  input  wire logic [11:0] vx_ra,
  output      logic [31:0] vx_rd,
  input  wire logic        lb_we,
  input  wire logic [8:0]  lb_wa,
  input  wire box_t        lb_wd,
  input  wire logic [8:0]  lb_ra,
  output      box_t        lb_rd,
  input  wire logic        fb_we,
  input  wire logic [7:0]  fb_wa,
  input  wire box_t        fb_wd,
  input  wire logic [7:0]  fb_ra,
  output      box_t        fb_rd
);
  logic [9:0]  fls_m [MAX_FACES];
  logic [12:0] les_m [MAX_LOOPS];
  logic [11:0] ev_m  [MAX_EDGES];
  logic [31:0] vx_m  [MAX_VERTICES];
  box_t        lb_m  [MAX_LOOPS];
  box_t        fb_m  [MAX_FACES];

  always_ff @(posedge clk) begin
    if (fls_we) fls_m[fls_wa] <= fls_wd;
    if (les_we) les_m[les_wa] <= les_wd;
    if (ev_we) ev_m[ev_wa] <= ev_wd;
    if (vx_we) vx_m[vx_wa] <= vx_wd;
    if (lb_we) lb_m[lb_wa] <= lb_wd;
    if (fb_we) fb_m[fb_wa] <= fb_wd;
    fls_rd <= fls_m[fls_ra];
    les_rd <= les_m[les_ra];
    ev_rd  <= ev_m[ev_ra];
    vx_rd  <= vx_m[vx_ra];
    lb_rd  <= lb_m[lb_ra];
    fb_rd  <= fb_m[fb_ra];
  end
endmodule
`default_nettype wire

// File: src/pfpl_cross.sv
// ----------------------------------------------------------------------------
// pfpl_cross
// edge crossing test: two-stage exact cross-multiplied compare
// ----------------------------------------------------------------------------
`default_nettype none
module pfpl_cross
  import pfpl_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               start,
  input  wire logic signed [15:0] ax,
  input  wire logic signed [15:0] ay,
  input  wire logic signed [15:0] bx,
  input  wire logic signed [15:0] by,
  input  wire logic signed [15:0] px,
  input  wire logic signed [15:0] py,
  output      logic               hit
);
  logic signed [15:0] tx, ty, ux, uy;
  logic               cand, sure;
  logic signed [16:0] d1, d2, d3, d4;
  logic signed [33:0] p1_r, p2_r;
  logic               cand_r, sure_r;

  always_comb begin
    if (by > ay) begin
      tx = bx; ty = by; ux = ax; uy = ay;
    end else begin
      tx = ax; ty = ay; ux = bx; uy = by;
    end
    cand = start && (by != ay) && ty >= py && uy < py && !(tx < px && ux < px);
    sure = tx > px && ux > px;
    d1 = 17'(tx) - 17'(px);
    d2 = 17'(uy) - 17'(ty);
    d3 = 17'(ty) - 17'(py);
    d4 = 17'(ux) - 17'(tx);
  end

  always_ff @(posedge clk) begin
    p1_r   <= 34'(d1) * 34'(d2);
    p2_r   <= 34'(d3) * 34'(d4);
    cand_r <= cand;
    sure_r <= sure;
  end

  assign hit = cand_r && (sure_r || p1_r <= p2_r);
endmodule
`default_nettype wire

// File: src/pfpl_ctrl.sv
// ----------------------------------------------------------------------------
// pfpl_ctrl
// sequencer for loads, box build and point queries
// ----------------------------------------------------------------------------
`default_nettype none
module pfpl_ctrl
  import pfpl_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  pfpl_in_if.sink          in_ch,
  pfpl_out_if.source       out_ch,
  pfpl_cfg_if.sink         cfg_ch,
  output      pfpl_cmd_t   cmd_o,
  output      logic        lbox_we,
  output      logic        fbox_we,
  output      logic        cross_go,
  output      logic        acc_clr,
  output      logic        acc_fclr,
  input  wire logic [9:0]  fls_rd,
  input  wire logic [12:0] les_rd,
  input  wire logic [11:0] ev_rd,
  input  wire logic        par_odd,
  input  wire logic        fbox_hit,
  input  wire logic        lbox_hit,
  output      logic [2:0]  ccmd_r,
  output      logic signed [15:0] cpx_r,
  output      logic signed [15:0] cpy_r,
  output      logic [11:0] cidx_r,
  output      logic [12:0] cval_r,
  output      logic [8:0]  lcur_o,
  output      logic [7:0]  fcur_o,
  output      logic        vx_sel
);
  localparam logic [4:0] S_IDLE = 5'd0, S_FS = 5'd1, S_FS2 = 5'd2, S_FE = 5'd3,
    S_FE2 = 5'd4, S_LS = 5'd5, S_LS2 = 5'd6, S_LE = 5'd7, S_LE2 = 5'd8,
    S_ED = 5'd9, S_ED2 = 5'd10, S_VX = 5'd11, S_VX2 = 5'd12, S_LDONE = 5'd13,
    S_FDONE = 5'd14, S_FB = 5'd15, S_FB2 = 5'd16, S_LB = 5'd17, S_LB2 = 5'd18,
    S_CW1 = 5'd19, S_CW2 = 5'd20, S_OUT = 5'd21, S_NEXTF = 5'd22;

  logic [4:0]  st_r, st_nxt;
  logic [8:0]  fc_r;
  logic [9:0]  lc_r;
  logic [12:0] ec_r;
  logic        hv_r;
  logic [7:0]  hf_r;
  logic [8:0]  f_r, f_nxt;
  logic        tryhint_r, tryhint_nxt;
  logic [9:0]  ls_r, ls_nxt, le_r, le_nxt;
  logic [12:0] es_r, es_nxt, ee_r, ee_nxt, k_r, k_nxt;
  logic        first_r, first_nxt;
  logic        found_r, found_nxt;
  logic [7:0]  fidx_r, fidx_nxt;
  logic        ov_r;
  logic [8:0]  fce;
  logic [9:0]  lce;
  logic        acc, build;

  assign fce = (fc_r > 9'(MAX_FACES)) ? 9'(MAX_FACES) : fc_r;
  assign lce = (lc_r > 10'(MAX_LOOPS)) ? 10'(MAX_LOOPS) : lc_r;
  assign in_ch.ready = (st_r == S_IDLE) && !ov_r;
  assign acc = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = ov_r;
  assign out_ch.found = found_r;
  assign out_ch.face_index = fidx_r;
  assign build = (ccmd_r == CMD_BUILD);
  assign lcur_o = ls_r[8:0];
  assign fcur_o = f_r[7:0];

  always_comb begin
    st_nxt = st_r; f_nxt = f_r; tryhint_nxt = tryhint_r;
    ls_nxt = ls_r; le_nxt = le_r; es_nxt = es_r; ee_nxt = ee_r; k_nxt = k_r;
    first_nxt = first_r; found_nxt = found_r; fidx_nxt = fidx_r;
    cmd_o = '{op: OP_NONE, addr: '0};
    lbox_we = 1'b0; fbox_we = 1'b0; cross_go = 1'b0;
    acc_clr = 1'b0; acc_fclr = 1'b0; vx_sel = 1'b0;
    unique case (st_r)
      S_IDLE: begin
        if (acc) begin
          unique case (in_ch.cmd)
            CMD_FACE, CMD_LOOP, CMD_EDGE, CMD_VERT: cmd_o.op = OP_LOAD;
            CMD_BUILD: begin
              f_nxt = '0;
              st_nxt = (fce == '0) ? S_IDLE : S_FS;
            end
            CMD_QUERY: begin
              tryhint_nxt = hv_r && ({1'b0, hf_r} < fce);
              f_nxt = (hv_r && ({1'b0, hf_r} < fce)) ? {1'b0, hf_r} : '0;
              st_nxt = S_NEXTF;
            end
            default: ;
          endcase
        end
      end
      S_NEXTF: begin
        // parity starts clear for every face tried
        acc_fclr = 1'b1;
        if (f_r >= fce) begin
          found_nxt = 1'b0; fidx_nxt = '0; st_nxt = S_OUT;
        end else begin
          cmd_o = '{op: OP_FBOX_RD, addr: 13'(f_r)};
          st_nxt = S_FB;
        end
      end
      S_FB: st_nxt = S_FB2;
      S_FB2: begin
        if (fbox_hit) begin
          cmd_o = '{op: OP_RD_FACE, addr: 13'(f_r)};
          st_nxt = S_FS;
        end else st_nxt = S_FDONE;
      end
      S_FS: begin
        cmd_o = '{op: OP_RD_FACE, addr: 13'(f_r)};
        acc_fclr = 1'b1;
        st_nxt = S_FS2;
      end
      S_FS2: begin
        ls_nxt = fls_rd;
        if (f_r + 9'd1 >= fce) begin
          le_nxt = lc_r; st_nxt = S_FE2;
        end else begin
          cmd_o = '{op: OP_RD_FACE, addr: 13'(f_r + 9'd1)};
          st_nxt = S_FE;
        end
      end
      S_FE: st_nxt = S_FE2;
      S_FE2: begin
        if (st_r == S_FE2 && le_r == lc_r && f_r + 9'd1 >= fce) le_nxt = lc_r;
        else le_nxt = fls_rd;
        if (le_nxt > 10'(MAX_LOOPS)) le_nxt = 10'(MAX_LOOPS);
        st_nxt = S_LS;
      end
      S_LS: begin
        if (ls_r >= le_r) st_nxt = S_FDONE;
        else if (build) begin
          cmd_o = '{op: OP_RD_LOOP, addr: 13'(ls_r)};
          acc_clr = 1'b1;
          st_nxt = S_LS2;
        end else begin
          cmd_o = '{op: OP_LBOX_RD, addr: 13'(ls_r)};
          st_nxt = S_LB;
        end
      end
      S_LB: st_nxt = S_LB2;
      S_LB2: begin
        if (lbox_hit) begin
          cmd_o = '{op: OP_RD_LOOP, addr: 13'(ls_r)};
          st_nxt = S_LS2;
        end else begin
          ls_nxt = ls_r + 10'd1; st_nxt = S_LS;
        end
      end
      S_LS2: begin
        es_nxt = les_rd;
        if (ls_r + 10'd1 >= lce) begin
          ee_nxt = ec_r; st_nxt = S_LE2; first_nxt = 1'b1;
        end else begin
          cmd_o = '{op: OP_RD_LOOP, addr: 13'(ls_r + 10'd1)};
          first_nxt = 1'b0;
          st_nxt = S_LE;
        end
      end
      S_LE: st_nxt = S_LE2;
      S_LE2: begin
        ee_nxt = first_r ? ee_r : les_rd;
        if (ee_nxt > 13'(MAX_EDGES)) ee_nxt = 13'(MAX_EDGES);
        if (es_r >= 13'(MAX_EDGES)) es_nxt = 13'(MAX_EDGES);
        k_nxt = es_r;
        first_nxt = 1'b1;
        st_nxt = (es_r >= ee_nxt) ? S_LDONE : S_ED;
      end
      // walk edges: read edge vertex, then vertex
      S_ED: begin
        cmd_o = '{op: OP_RD_EDGE, addr: k_r};
        st_nxt = S_ED2;
      end
      S_ED2: begin
        cmd_o = '{op: OP_RD_VERT, addr: {1'b0, ev_rd}};
        st_nxt = S_VX;
      end
      S_VX: st_nxt = S_VX2;
      S_VX2: begin
        vx_sel = 1'b1;
        cross_go = !build && !first_r;
        first_nxt = 1'b0;
        if (first_r && !build) begin
          // first vertex only primes the closing loop
          k_nxt = (k_r + 13'd1 == ee_r) ? es_r : k_r + 13'd1;
          st_nxt = S_ED;
        end else if (k_r == es_r && !build) st_nxt = S_CW1;
        else if (build && k_r + 13'd1 >= ee_r) st_nxt = S_LDONE;
        else begin
          k_nxt = (k_r + 13'd1 == ee_r) ? es_r : k_r + 13'd1;
          st_nxt = S_ED;
        end
      end
      S_CW1: st_nxt = S_CW2;
      S_CW2: st_nxt = S_LDONE;
      S_LDONE: begin
        lbox_we = build;
        ls_nxt = ls_r + 10'd1;
        st_nxt = S_LS;
      end
      S_FDONE: begin
        if (build) begin
          fbox_we = 1'b1;
          f_nxt = f_r + 9'd1;
          st_nxt = (f_r + 9'd1 >= fce) ? S_IDLE : S_FS;
        end else if (par_odd && st_r == S_FDONE && ls_r >= le_r) begin
          found_nxt = 1'b1; fidx_nxt = f_r[7:0]; st_nxt = S_OUT;
        end else begin
          f_nxt = tryhint_r ? '0 : f_r + 9'd1;
          if (tryhint_r) tryhint_nxt = 1'b0;
          st_nxt = S_NEXTF;
        end
      end
      S_OUT: st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; fc_r <= '0; lc_r <= '0; ec_r <= '0;
      hv_r <= 1'b0; hf_r <= '0; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          REG_FACE_COUNT: fc_r <= cfg_ch.data[8:0];
          REG_LOOP_COUNT: lc_r <= cfg_ch.data[9:0];
          REG_EDGE_COUNT: ec_r <= cfg_ch.data;
          default: ;
        endcase
      end
      if (st_r == S_OUT) begin
        ov_r <= 1'b1;
        hv_r <= found_r;
        hf_r <= found_r ? fidx_r : 8'd0;
      end else if (ov_r && out_ch.ready) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    f_r <= f_nxt; tryhint_r <= tryhint_nxt; ls_r <= ls_nxt; le_r <= le_nxt;
    es_r <= es_nxt; ee_r <= ee_nxt; k_r <= k_nxt; first_r <= first_nxt;
    found_r <= found_nxt; fidx_r <= fidx_nxt;
    if (acc) begin
      ccmd_r <= in_ch.cmd; cpx_r <= in_ch.point_x; cpy_r <= in_ch.point_y;
      cidx_r <= in_ch.index; cval_r <= in_ch.start_value;
    end
  end
endmodule
`default_nettype wire

// File: src/pfpl_dp.sv
// ----------------------------------------------------------------------------
// pfpl_dp
// datapath: tables, box accumulators, crossing unit and parity
// ----------------------------------------------------------------------------
`default_nettype none
module pfpl_dp
  import pfpl_pkg::*;
(
  input  wire logic        clk,
  input  wire pfpl_cmd_t   cmd_i,
  input  wire logic        ld_go,
  input  wire logic [2:0]  ld_cmd,
  input  wire logic [11:0] ld_idx,
  input  wire logic [12:0] ld_val,
  input  wire logic signed [15:0] ld_x,
  input  wire logic signed [15:0] ld_y,
  input  wire logic signed [15:0] px,
  input  wire logic signed [15:0] py,
  input  wire logic        lbox_we,
  input  wire logic        fbox_we,
  input  wire logic [8:0]  lcur,
  input  wire logic [7:0]  fcur,
  input  wire logic        vx_sel,
  input  wire logic        cross_go,
  input  wire logic        acc_clr,
  input  wire logic        acc_fclr,
  output      logic [9:0]  fls_rd,
  output      logic [12:0] les_rd,
  output      logic [11:0] ev_rd,
  output      logic        par_odd,
  output      logic        fbox_hit,
  output      logic        lbox_hit
);
  logic [31:0] vx_rd;
  box_t        lb_rd, fb_rd, lacc_r, facc_r, lb_merged;
  logic        vok_r;
  logic signed [15:0] vx, vy, ax_r, ay_r;
  logic        hit, par_r;
  logic [11:0] vra;
  logic [12:0] ra, ra_r;

  // wait cycles issue no command, so the last read address is held
  assign ra = (cmd_i.op != OP_NONE) ? cmd_i.addr : ra_r;
  always_ff @(posedge clk) begin
    if (cmd_i.op != OP_NONE) ra_r <= cmd_i.addr;
  end

  assign vra = ra[11:0];

  pfpl_mem u_mem (
    .clk(clk),
    .fls_we(ld_go && ld_cmd == CMD_FACE && ld_idx < 12'(MAX_FACES)),
    .fls_wa(ld_idx[7:0]), .fls_wd(ld_val[9:0]),
    .fls_ra(ra[7:0]), .fls_rd(fls_rd),
    .les_we(ld_go && ld_cmd == CMD_LOOP && ld_idx < 12'(MAX_LOOPS)),
    .les_wa(ld_idx[8:0]), .les_wd(ld_val),
    .les_ra(ra[8:0]), .les_rd(les_rd),
    .ev_we(ld_go && ld_cmd == CMD_EDGE),
    .ev_wa(ld_idx), .ev_wd(ld_val[11:0]),
    .ev_ra(ra[11:0]), .ev_rd(ev_rd),
    .vx_we(ld_go && ld_cmd == CMD_VERT),
    .vx_wa(ld_idx), .vx_wd({ld_x, ld_y}),
    .vx_ra(vra), .vx_rd(vx_rd),
    .lb_we(lbox_we), .lb_wa(lcur), .lb_wd(lacc_r),
    .lb_ra(ra[8:0]), .lb_rd(lb_rd),
    .fb_we(fbox_we), .fb_wa(fcur), .fb_wd(facc_r),
    .fb_ra(ra[7:0]), .fb_rd(fb_rd)
  );

  // vertex reads are always used as read; a 12-bit vertex index never reaches 4096
  always_ff @(posedge clk) vok_r <= 1'b1;
  assign vx = vok_r ? vx_rd[31:16] : 16'sd0;
  assign vy = vok_r ? vx_rd[15:0] : 16'sd0;
  assign fbox_hit = box_has(fb_rd, px, py);
  assign lbox_hit = box_has(lb_rd, px, py);

  pfpl_cross u_cross (
    .clk(clk), .start(cross_go), .ax(ax_r), .ay(ay_r), .bx(vx), .by(vy),
    .px(px), .py(py), .hit(hit)
  );

  always_comb begin
    lb_merged = facc_r;
    if (lacc_r.lx < lb_merged.lx) lb_merged.lx = lacc_r.lx;
    if (lacc_r.hx > lb_merged.hx) lb_merged.hx = lacc_r.hx;
    if (lacc_r.ly < lb_merged.ly) lb_merged.ly = lacc_r.ly;
    if (lacc_r.hy > lb_merged.hy) lb_merged.hy = lacc_r.hy;
  end

  always_ff @(posedge clk) begin
    if (vx_sel) begin
      ax_r <= vx; ay_r <= vy;
    end
    if (acc_fclr) begin
      facc_r <= '{lx: CMAX, ly: CMAX, hx: CMIN, hy: CMIN};
      par_r  <= 1'b0;
    end else begin
      if (lbox_we) facc_r <= lb_merged;
      if (hit) par_r <= ~par_r;
    end
    if (acc_clr) lacc_r <= '{lx: CMAX, ly: CMAX, hx: CMIN, hy: CMIN};
    else if (vx_sel) begin
      if (vx < lacc_r.lx) lacc_r.lx <= vx;
      if (vx > lacc_r.hx) lacc_r.hx <= vx;
      if (vy < lacc_r.ly) lacc_r.ly <= vy;
      if (vy > lacc_r.hy) lacc_r.hy <= vy;
    end
  end

  assign par_odd = par_r;
endmodule
`default_nettype wire

// File: src/planar_face_point_locator_unit.sv
// ----------------------------------------------------------------------------
// planar_face_point_locator_unit
// point location in a planar mesh by ray crossings with bounding boxes
// ----------------------------------------------------------------------------
// channel  dir  word
// in_      in   cmd, index, start_value, point_x, point_y
// out_     out  found, face_index (queries only)
// cfg_     in   index, data (face, loop, edge counts)
// loads write the tables straight from the accepted word; build and query walk faces,
// loops and edges through tables with one registered read port each
// one item in flight; next item taken once the result register is free
// rst_n clears the sequencer, counts and hint; the tables have no reset
`default_nettype none
module planar_face_point_locator_unit
  import pfpl_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  pfpl_in_if.sink    in_ch,
  pfpl_out_if.source out_ch,
  pfpl_cfg_if.sink   cfg_ch
);
  pfpl_cmd_t   cmd;
  logic        lbox_we, fbox_we, cross_go, acc_clr, acc_fclr, vx_sel;
  logic [9:0]  fls_rd;
  logic [12:0] les_rd;
  logic [11:0] ev_rd;
  logic        par_odd, fbox_hit, lbox_hit;
  logic [2:0]  ccmd;
  logic signed [15:0] cpx, cpy;
  logic [11:0] cidx;
  logic [12:0] cval;
  logic [8:0]  lcur;
  logic [7:0]  fcur;

  pfpl_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch),
    .cmd_o(cmd), .lbox_we(lbox_we), .fbox_we(fbox_we), .cross_go(cross_go),
    .acc_clr(acc_clr), .acc_fclr(acc_fclr), .fls_rd(fls_rd), .les_rd(les_rd),
    .ev_rd(ev_rd), .par_odd(par_odd), .fbox_hit(fbox_hit), .lbox_hit(lbox_hit),
    .ccmd_r(ccmd), .cpx_r(cpx), .cpy_r(cpy), .cidx_r(cidx), .cval_r(cval),
    .lcur_o(lcur), .fcur_o(fcur), .vx_sel(vx_sel)
  );

  pfpl_dp u_dp (
    .clk(clk), .cmd_i(cmd), .ld_go(cmd.op == OP_LOAD),
    .ld_cmd(in_ch.cmd), .ld_idx(in_ch.index), .ld_val(in_ch.start_value),
    .ld_x(in_ch.point_x), .ld_y(in_ch.point_y), .px(cpx), .py(cpy),
    .lbox_we(lbox_we), .fbox_we(fbox_we), .lcur(lcur), .fcur(fcur),
    .vx_sel(vx_sel), .cross_go(cross_go), .acc_clr(acc_clr), .acc_fclr(acc_fclr),
    .fls_rd(fls_rd), .les_rd(les_rd), .ev_rd(ev_rd), .par_odd(par_odd),
    .fbox_hit(fbox_hit), .lbox_hit(lbox_hit)
  );

  // load word fields are consumed directly; registered copies kept for debug
  logic unused_ok;
  assign unused_ok = ^{ccmd, cidx, cval};
endmodule
`default_nettype wire

// File: src/pfpl_checker.sv
// ----------------------------------------------------------------------------
// pfpl_checker
// port-level checks of the face point locator
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module pfpl_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       out_found,
  input wire logic [7:0] out_face_index
);
  `CHK_IMPL(a_nf_zero, out_valid && !out_found, out_face_index == 8'd0)
  `CHK_IMPL(a_busy_out, out_valid, !in_ready)
  `CHK_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_face_index))
  `CHK_NEXT(a_found_hold, out_valid && !out_ready, $stable(out_found))
endmodule

bind planar_face_point_locator_unit pfpl_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_found(out_ch.found),
  .out_face_index(out_ch.face_index)
);
`default_nettype wire

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// face point locator check: meshes are loaded, boxes built and points located
// against a cycle-free predictor that walks the same faces, loops and edges
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top;
  import pfpl_pkg::*;

  localparam int        LIMIT       = 1000000;
  localparam int        LONG_HOLD   = 300;
  localparam logic [2:0] CMD_SPARE_A = 3'd6;
  localparam logic [2:0] CMD_SPARE_B = 3'd7;
  localparam logic [1:0] REG_SPARE   = 2'd3;

  typedef struct {
    int lx;
    int ly;
    int hx;
    int hy;
  } area_t;

  typedef struct {
    bit found;
    int face;
  } hit_t;

  // mesh predictor and store of expected query answers
  class face_locator_sb;
    int unsigned n_faces, n_loops, n_edges;
    int    face_start[MAX_FACES];
    int    loop_start[MAX_LOOPS];
    int    edge_vtx[MAX_EDGES];
    int    vx[MAX_VERTICES];
    int    vy[MAX_VERTICES];
    area_t lbox[MAX_LOOPS];
    area_t fbox[MAX_FACES];
    bit    hint_ok;
    int    hint_f;
    hit_t  answers[$];
    int    errors;

    function new();
      n_faces = 0; n_loops = 0; n_edges = 0;
      hint_ok = 0; hint_f = 0; errors = 0;
    endfunction

    function int pending();
      return answers.size();
    endfunction

    function void set_reg(logic [1:0] idx, logic [12:0] data);
      case (idx)
        REG_FACE_COUNT: n_faces = data[8:0];
        REG_LOOP_COUNT: n_loops = data[9:0];
        REG_EDGE_COUNT: n_edges = data;
        default: ;
      endcase
    endfunction

    function void face_span(int f, output int s, output int e);
      int fc;
      fc = (n_faces < MAX_FACES) ? n_faces : MAX_FACES;
      s = face_start[f];
      e = (f + 1 >= fc) ? n_loops : face_start[f + 1];
      if (e > MAX_LOOPS) e = MAX_LOOPS;
    endfunction

    function void loop_span(int l, output int s, output int e);
      int lc;
      lc = (n_loops < MAX_LOOPS) ? n_loops : MAX_LOOPS;
      s = loop_start[l];
      e = (l + 1 >= lc) ? n_edges : loop_start[l + 1];
      if (e > MAX_EDGES) e = MAX_EDGES;
    endfunction

    function bit strictly_in(area_t b, int px, int py);
      return b.lx < px && b.hx > px && b.ly < py && b.hy > py;
    endfunction

    function int ray_hits(int l, int px, int py);
      int s, e, k, nk, cnt;
      longint ax, ay, bx, by, tx, ty, ux, uy;
      cnt = 0;
      loop_span(l, s, e);
      if (e <= s) return 0;
      ax = vx[edge_vtx[s]]; ay = vy[edge_vtx[s]];
      for (k = s; k < e; k++) begin
        nk = (k + 1 == e) ? s : k + 1;
        bx = vx[edge_vtx[nk]]; by = vy[edge_vtx[nk]];
        // horizontal edges never count
        if (by != ay) begin
          if (by > ay) begin
            tx = bx; ty = by; ux = ax; uy = ay;
          end else begin
            tx = ax; ty = ay; ux = bx; uy = by;
          end
          if (ty >= py && uy < py && !(tx < px && ux < px)) begin
            if (tx > px && ux > px) cnt++;
            else if ((tx - px) * (uy - ty) <= (ty - py) * (ux - tx)) cnt++;
          end
        end
        ax = bx; ay = by;
      end
      return cnt;
    endfunction

    function bit face_holds(int f, int px, int py);
      int s, e, l, cnt;
      cnt = 0;
      if (!strictly_in(fbox[f], px, py)) return 0;
      face_span(f, s, e);
      for (l = s; l < e; l++)
        if (strictly_in(lbox[l], px, py)) cnt += ray_hits(l, px, py);
      return cnt[0];
    endfunction

    function void build_boxes();
      int fc, f, l, k, ls, le, es, ee, x, y;
      area_t fb, lb;
      fc = (n_faces < MAX_FACES) ? n_faces : MAX_FACES;
      for (f = 0; f < fc; f++) begin
        fb = '{CMAX, CMAX, CMIN, CMIN};
        face_span(f, ls, le);
        for (l = ls; l < le; l++) begin
          lb = '{CMAX, CMAX, CMIN, CMIN};
          loop_span(l, es, ee);
          for (k = es; k < ee; k++) begin
            x = vx[edge_vtx[k]]; y = vy[edge_vtx[k]];
            if (x < lb.lx) lb.lx = x;
            if (x > lb.hx) lb.hx = x;
            if (y < lb.ly) lb.ly = y;
            if (y > lb.hy) lb.hy = y;
          end
          if (lb.lx < fb.lx) fb.lx = lb.lx;
          if (lb.hx > fb.hx) fb.hx = lb.hx;
          if (lb.ly < fb.ly) fb.ly = lb.ly;
          if (lb.hy > fb.hy) fb.hy = lb.hy;
          lbox[l] = lb;
        end
        fbox[f] = fb;
      end
    endfunction

    function void locate(int px, int py);
      int fc, f;
      fc = (n_faces < MAX_FACES) ? n_faces : MAX_FACES;
      if (hint_ok && hint_f < fc && face_holds(hint_f, px, py)) begin
        answers.push_back('{1'b1, hint_f});
        return;
      end
      for (f = 0; f < fc; f++)
        if (face_holds(f, px, py)) begin
          hint_ok = 1; hint_f = f;
          answers.push_back('{1'b1, f});
          return;
        end
      hint_ok = 0; hint_f = 0;
      answers.push_back('{1'b0, 0});
    endfunction

    function void note_item(logic [2:0] cmd, logic [11:0] idx, logic [12:0] val,
                            int px, int py);
      case (cmd)
        CMD_FACE:  if (idx < MAX_FACES) face_start[idx] = val[9:0];
        CMD_LOOP:  if (idx < MAX_LOOPS) loop_start[idx] = val;
        CMD_EDGE:  edge_vtx[idx] = val[11:0];
        CMD_VERT: begin
          vx[idx] = px; vy[idx] = py;
        end
        CMD_BUILD: build_boxes();
        CMD_QUERY: locate(px, py);
        default: ;
      endcase
    endfunction

    function void check_result(logic found, logic [7:0] face_index);
      hit_t exp_hit;
      if (answers.size() == 0) begin
        $error("result with nothing expected: found=%0d face_index=%0d", found, face_index);
        errors++;
        return;
      end
      exp_hit = answers.pop_front();
      if (found !== exp_hit.found) begin
        $error("found: expected %0d, got %0d", exp_hit.found, found);
        errors++;
      end
      if (face_index !== exp_hit.face[7:0]) begin
        $error("face_index: expected %0d, got %0d", exp_hit.face[7:0], face_index);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   idle_on;
  int   hold_left;
  int   cycles;
  face_locator_sb sb;

  pfpl_in_if  in_if();
  pfpl_out_if out_if();
  pfpl_cfg_if cfg_if();

  planar_face_point_locator_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // accepted words go to the predictor, results are checked in order
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_if.valid && out_if.ready) sb.check_result(out_if.found, out_if.face_index);
      if (in_if.valid && in_if.ready)
        sb.note_item(in_if.cmd, in_if.index, in_if.start_value, in_if.point_x,
                     in_if.point_y);
      if (cfg_if.valid && cfg_if.ready) sb.set_reg(cfg_if.index, cfg_if.data);
    end
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_if.ready <= 1'b0;
      hold_left--;
    end else begin
      out_if.ready <= !(idle_on && $urandom_range(99) < 21);
    end
  end

  task automatic send(logic [2:0] cmd, logic [11:0] idx, logic [12:0] val,
                      logic [15:0] px, logic [15:0] py);
    if (idle_on)
      while ($urandom_range(99) < 21) begin
        in_if.valid <= 1'b0;
        @(negedge clk);
      end
    in_if.valid       <= 1'b1;
    in_if.cmd         <= cmd;
    in_if.index       <= idx;
    in_if.start_value <= val;
    in_if.point_x     <= px;
    in_if.point_y     <= py;
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic set_counts(int nf, int nl, int ne);
    logic [1:0]  regs[3];
    logic [12:0] vals[3];
    regs = '{REG_FACE_COUNT, REG_LOOP_COUNT, REG_EDGE_COUNT};
    vals = '{nf, nl, ne};
    for (int i = 0; i < 3; i++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= regs[i];
      cfg_if.data  <= vals[i];
      do @(posedge clk); while (!cfg_if.ready);
      @(negedge clk);
    end
    cfg_if.valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [15:0] rand_coord();
    if ($urandom_range(9) == 0) return $urandom_range(65535);
    return 16'($signed($urandom_range(80)) - 40);
  endfunction

  // loads and spare commands with random fields; loads are never read back before being rewritten
  task automatic noise(int n);
    logic [2:0] c;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(5))
        0: c = CMD_FACE;
        1: c = CMD_LOOP;
        2: c = CMD_EDGE;
        3: c = CMD_VERT;
        4: c = CMD_SPARE_A;
        default: c = CMD_SPARE_B;
      endcase
      send(c, $urandom_range(4095), $urandom_range(8191), $urandom_range(65535),
           $urandom_range(65535));
    end
  endtask

  task automatic query_near(int nv, int nq);
    logic [15:0] qx, qy;
    int v;
    for (int q = 0; q < nq; q++) begin
      v = $urandom_range(nv - 1);
      case ($urandom_range(3))
        0: begin
          qx = sb.vx[v]; qy = sb.vy[v];
        end
        1: begin
          qx = 16'(sb.vx[v] + $signed($urandom_range(2)) - 1);
          qy = 16'(sb.vy[v] + $signed($urandom_range(2)) - 1);
        end
        default: begin
          qx = rand_coord(); qy = rand_coord();
        end
      endcase
      send(CMD_QUERY, $urandom_range(4095), $urandom_range(8191), qx, qy);
    end
  endtask

  task automatic random_phase(int max_faces, int nq, bit fill_all, bit hold);
    int nf, nl, ne, nv, nloops;
    int fst[$];
    int lst[$];
    nf = $urandom_range(max_faces, 1);
    nv = $urandom_range(8, 3);
    nl = 0; ne = 0;
    for (int f = 0; f < nf; f++) begin
      fst.push_back(nl);
      nloops = $urandom_range(2);
      for (int l = 0; l < nloops; l++) begin
        lst.push_back(ne);
        ne += $urandom_range(5);
      end
      nl += nloops;
    end
    set_counts(fill_all ? MAX_FACES : nf, nl, ne);
    noise($urandom_range(8, 3));
    for (int k = 0; k < nv; k++)
      send(CMD_VERT, k, $urandom_range(8191), rand_coord(), rand_coord());
    // high bits of a face start are dropped by the block
    for (int f = 0; f < nf; f++)
      send(CMD_FACE, f, 13'(fst[f] | ($urandom_range(7) << 10)), $urandom_range(65535),
           $urandom_range(65535));
    // unused faces start at the loop count, so their ranges are empty
    if (fill_all)
      for (int f = nf; f < MAX_FACES; f++) send(CMD_FACE, f, nl, 16'd0, 16'd0);
    for (int l = 0; l < nl; l++) send(CMD_LOOP, l, lst[l], rand_coord(), rand_coord());
    for (int k = 0; k < ne; k++)
      send(CMD_EDGE, k, 13'($urandom_range(nv - 1) | ($urandom_range(1) << 12)),
           rand_coord(), rand_coord());
    send(CMD_BUILD, $urandom_range(4095), $urandom_range(8191), rand_coord(), rand_coord());
    if (hold) begin
      @(posedge clk);
      hold_left = LONG_HOLD;
      @(negedge clk);
    end
    query_near(nv, nq);
    drain();
  endtask

  task automatic directed_phase();
    int dvx[10] = '{-10, 10, 10, -10, -3, 3, 0, -32768, 32767, 0};
    int dvy[10] = '{-10, -10, 10, 10, -3, -3, 4, -32768, -32768, 32767};
    int dls[4]  = '{0, 4, 7, 10};
    int dfs[3]  = '{0, 2, 2};
    int qx[8]   = '{0, 5, 5, 10, 0, -32768, 32767, -9};
    int qy[8]   = '{0, 5, 5, 0, -9, 32767, -32768, 9};
    // outer square with a hole, an empty face, then a huge triangle and an empty loop
    set_counts(3, 4, 10);
    for (int k = 0; k < 10; k++) send(CMD_VERT, k, 13'd0, dvx[k], dvy[k]);
    for (int k = 0; k < 10; k++) send(CMD_EDGE, k, k, 16'd0, 16'd0);
    for (int l = 0; l < 4; l++) send(CMD_LOOP, l, dls[l], 16'd0, 16'd0);
    for (int f = 0; f < 3; f++) send(CMD_FACE, f, dfs[f], 16'd0, 16'd0);
    send(CMD_BUILD, 12'd0, 13'd0, 16'd0, 16'd0);
    for (int q = 0; q < 8; q++) send(CMD_QUERY, 12'd0, 13'd0, qx[q], qy[q]);
    send(CMD_SPARE_A, 12'hfff, 13'h1fff, 16'hffff, 16'hffff);
    send(CMD_SPARE_B, 12'd0, 13'd0, 16'h8000, 16'h7fff);
    send(CMD_FACE, 12'hfff, 13'h1000, 16'd0, 16'd0);
    send(CMD_QUERY, 12'hfff, 13'h1fff, 16'sd5, -16'sd5);
    drain();
  endtask

  initial begin
    sb = new();
    idle_on = 1;
    hold_left = 0;
    cycles = 0;
    rst_n = 0;
    in_if.valid = 0;
    in_if.cmd = '0;
    in_if.index = '0;
    in_if.start_value = '0;
    in_if.point_x = '0;
    in_if.point_y = '0;
    out_if.ready = 0;
    cfg_if.valid = 0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    directed_phase();
    // a phase with a single face; only a remembered hint of face 0 is in range
    random_phase(1, 4, 0, 0);
    idle_on = 0;
    random_phase(4, 8, 0, 0);
    idle_on = 1;
    random_phase(3, 10, 0, 1);
    random_phase(4, 8, 0, 0);

    // largest loop and edge counts with every face range empty
    set_counts(3, MAX_LOOPS, MAX_EDGES);
    for (int f = 0; f < 3; f++) send(CMD_FACE, f, 13'd600, 16'd0, 16'd0);
    send(CMD_BUILD, 12'd0, 13'd0, 16'd0, 16'd0);
    send(CMD_QUERY, 12'd0, 13'd0, 16'd0, 16'd0);
    drain();

    // nothing in use at all
    set_counts(0, 0, 0);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= REG_SPARE;
    cfg_if.data  <= $urandom_range(8191);
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
    send(CMD_BUILD, 12'd0, 13'd0, 16'd0, 16'd0);
    send(CMD_QUERY, 12'd0, 13'd0, 16'd1, 16'd1);
    drain();

    repeat (200) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end
endmodule
`default_nettype wire

// File: sim.f
+incdir+src
src/pfpl_pkg.sv
src/pfpl_if.sv
src/pfpl_mem.sv
src/pfpl_cross.sv
src/pfpl_ctrl.sv
src/pfpl_dp.sv
src/planar_face_point_locator_unit.sv
src/pfpl_checker.sv
dv/tb_top.sv
